FILE: hw/rtl/sjft_pkg.sv
// Shared constants, payload types and controller/datapath command types
// for the shortest-job-first timing block. No dependencies.
`timescale 1ns / 1ps

package sjft_pkg;

    localparam int MAX_JOBS = 16;
    localparam int TAG_W    = 8;
    localparam int BURST_W  = 16;
    localparam int TIME_W   = 20;
    localparam int AVG_W    = 28;
    localparam int FRAC_W   = 8;

    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int IDX_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int ELAP_W = (BURST_W + CNT_W > TIME_W) ? (BURST_W + CNT_W) : TIME_W;
    localparam int SUM_W  = ELAP_W + CNT_W;
    localparam int DIVD_W = SUM_W + FRAC_W;
    localparam int DCNT_W = $clog2(DIVD_W + 1);
    localparam int ENT_W  = TAG_W + BURST_W;

    localparam logic [1:0] WR_IN  = 2'd0;
    localparam logic [1:0] WR_RD  = 2'd1;
    localparam logic [1:0] WR_KEY = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0]   job_tag;
        logic [BURST_W-1:0] job_burst;
        logic               final_job;
    } t_in;

    typedef struct packed {
        logic [TAG_W-1:0]   out_tag;
        logic [BURST_W-1:0] out_burst;
        logic [TIME_W-1:0]  wait_time;
        logic [TIME_W-1:0]  turnaround;
        logic [AVG_W-1:0]   avg_wait;
        logic [AVG_W-1:0]   avg_turnaround;
        logic               last_result;
    } t_out;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [BURST_W-1:0] burst;
    } t_entry;

    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [1:0]       wr_sel;
        logic             key_ld;
        logic             sum_clr;
        logic             sum_acc;
        logic             elap_clr;
        logic             div_start;
        logic             out_ld;
        logic             out_last;
    } t_cmd;

    typedef struct packed {
        logic gt;
        logic div_done;
        logic out_taken;
    } t_sts;

endpackage

FILE: hw/rtl/sjft_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sjft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/sjft_div.sv
// Restoring divider, one quotient bit per cycle, for the fixed-point averages.
// Depends on sjft_pkg.
`timescale 1ns / 1ps

module sjft_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sjft_pkg::DIVD_W-1:0] i_dividend,
    input  logic [sjft_pkg::CNT_W-1:0]  i_divisor,
    output logic                      o_done,
    output logic [sjft_pkg::AVG_W-1:0]  o_quot
);
    import sjft_pkg::*;

    logic [DIVD_W-1:0] r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [CNT_W:0]    w_sh;
    logic [CNT_W:0]    w_diff;
    logic              w_ge;

    assign w_sh   = {r_rem, r_q[DIVD_W-1]};
    assign w_ge   = (w_sh >= {1'b0, i_divisor});
    assign w_diff = w_sh - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DCNT_W'(DIVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DCNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[DIVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_sh[CNT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[AVG_W-1:0];

endmodule

FILE: hw/rtl/sjft_dp.sv
// Datapath: job store, sort key, running sums, average dividers, result register.
// Depends on sjft_pkg, sjft_ram, sjft_div.
`timescale 1ns / 1ps

module sjft_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sjft_pkg::t_in           i_in_data,
    input  logic [sjft_pkg::CNT_W-1:0] i_count,
    input  sjft_pkg::t_cmd          i_cmd,
    output sjft_pkg::t_sts          o_sts,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output sjft_pkg::t_out          o_out_data
);
    import sjft_pkg::*;

    t_entry            w_rdata;
    logic [ENT_W-1:0]  w_rdata_raw;
    t_entry            w_wdata;
    t_entry            r_key;
    logic [ELAP_W-1:0] r_elap;
    logic [ELAP_W-1:0] w_elap_nx;
    logic [SUM_W-1:0]  r_wsum;
    logic [SUM_W-1:0]  w_tsum;
    logic              w_wdone;
    logic              w_tdone;
    logic [AVG_W-1:0]  w_wavg;
    logic [AVG_W-1:0]  w_tavg;
    t_out              r_out;
    logic              r_out_valid;

    always_comb begin
        case (i_cmd.wr_sel)
            WR_IN:   w_wdata = '{tag: i_in_data.job_tag, burst: i_in_data.job_burst};
            WR_RD:   w_wdata = w_rdata;
            WR_KEY:  w_wdata = r_key;
            default: w_wdata = w_rdata;
        endcase
    end

    sjft_ram #(.WIDTH(ENT_W), .DEPTH(MAX_JOBS), .AW(IDX_W)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (i_cmd.wr_addr),
        .i_wdata (w_wdata),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (w_rdata_raw)
    );
    assign w_rdata = w_rdata_raw;

    assign w_elap_nx = r_elap + ELAP_W'(w_rdata.burst);
    assign w_tsum    = r_wsum + SUM_W'(r_elap);

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_ld) begin
            r_key <= w_rdata;
        end
        if (i_cmd.sum_clr || i_cmd.elap_clr) begin
            r_elap <= '0;
        end else if (i_cmd.sum_acc || i_cmd.out_ld) begin
            r_elap <= w_elap_nx;
        end
        if (i_cmd.sum_clr) begin
            r_wsum <= '0;
        end else if (i_cmd.sum_acc) begin
            r_wsum <= r_wsum + SUM_W'(r_elap);
        end
    end

    // total turnaround = total wait + final elapsed time
    sjft_div u_div_wait (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({r_wsum, FRAC_W'(0)}),
        .i_divisor  (i_count),
        .o_done     (w_wdone),
        .o_quot     (w_wavg)
    );

    sjft_div u_div_turn (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({w_tsum, FRAC_W'(0)}),
        .i_divisor  (i_count),
        .o_done     (w_tdone),
        .o_quot     (w_tavg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out.out_tag        <= w_rdata.tag;
            r_out.out_burst      <= w_rdata.burst;
            r_out.wait_time      <= r_elap[TIME_W-1:0];
            r_out.turnaround     <= w_elap_nx[TIME_W-1:0];
            r_out.avg_wait       <= i_cmd.out_last ? w_wavg : '0;
            r_out.avg_turnaround <= i_cmd.out_last ? w_tavg : '0;
            r_out.last_result    <= i_cmd.out_last;
        end
    end

    assign o_sts.gt        = (w_rdata.burst > r_key.burst);
    assign o_sts.div_done  = w_wdone & w_tdone;
    assign o_sts.out_taken = r_out_valid & i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: hw/rtl/sjft_ctrl.sv
// Controller: load, insertion sort, sum pass, divide and emit sequencing.
// Depends on sjft_pkg.
`timescale 1ns / 1ps

module sjft_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_final,
    output logic                    o_in_ready,
    output logic [sjft_pkg::CNT_W-1:0] o_count,
    output sjft_pkg::t_cmd          o_cmd,
    input  sjft_pkg::t_sts          i_sts
);
    import sjft_pkg::*;

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_SI   = 4'd1;
    localparam logic [3:0] S_SK   = 4'd2;
    localparam logic [3:0] S_SC   = 4'd3;
    localparam logic [3:0] S_SW   = 4'd4;
    localparam logic [3:0] S_UR   = 4'd5;
    localparam logic [3:0] S_UA   = 4'd6;
    localparam logic [3:0] S_DS   = 4'd7;
    localparam logic [3:0] S_DW   = 4'd8;
    localparam logic [3:0] S_ER   = 4'd9;
    localparam logic [3:0] S_EL   = 4'd10;
    localparam logic [3:0] S_EW   = 4'd11;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] w_cnt_inc;
    logic [CNT_W-1:0] w_k_inc;
    logic             w_k_last;
    t_cmd             w_cmd;

    assign w_cnt_inc = r_cnt + 1'b1;
    assign w_k_inc   = r_k + 1'b1;
    assign w_k_last  = (w_k_inc == r_cnt);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        w_cmd   = '0;
        w_cmd.wr_sel = WR_IN;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    w_cmd.wr_en   = 1'b1;
                    w_cmd.wr_addr = IDX_W'(r_cnt);
                    w_cmd.wr_sel  = WR_IN;
                    n_cnt = w_cnt_inc;
                    if (i_final || (w_cnt_inc == CNT_W'(MAX_JOBS))) begin
                        n_i     = CNT_W'(1);
                        n_state = S_SI;
                    end
                end
            end
            S_SI: begin
                if (r_i >= r_cnt) begin
                    n_state = S_UR;
                end else begin
                    w_cmd.rd_addr = IDX_W'(r_i);
                    n_state = S_SK;
                end
            end
            S_SK: begin
                w_cmd.key_ld  = 1'b1;
                w_cmd.rd_addr = IDX_W'(r_i - 1'b1);
                n_j     = r_i;
                n_state = S_SC;
            end
            S_SC: begin
                w_cmd.wr_en   = 1'b1;
                w_cmd.wr_addr = IDX_W'(r_j);
                if (i_sts.gt) begin
                    w_cmd.wr_sel = WR_RD;
                    n_j = r_j - 1'b1;
                    if (r_j == CNT_W'(1)) begin
                        n_state = S_SW;
                    end else begin
                        w_cmd.rd_addr = IDX_W'(r_j - CNT_W'(2));
                    end
                end else begin
                    w_cmd.wr_sel = WR_KEY;
                    n_i     = r_i + 1'b1;
                    n_state = S_SI;
                end
            end
            S_SW: begin
                w_cmd.wr_en   = 1'b1;
                w_cmd.wr_addr = IDX_W'(r_j);
                w_cmd.wr_sel  = WR_KEY;
                n_i     = r_i + 1'b1;
                n_state = S_SI;
            end
            S_UR: begin
                w_cmd.sum_clr = 1'b1;
                w_cmd.rd_addr = '0;
                n_k     = '0;
                n_state = S_UA;
            end
            S_UA: begin
                w_cmd.sum_acc = 1'b1;
                n_k = w_k_inc;
                if (w_k_last) begin
                    n_state = S_DS;
                end else begin
                    w_cmd.rd_addr = IDX_W'(w_k_inc);
                end
            end
            S_DS: begin
                w_cmd.div_start = 1'b1;
                n_state = S_DW;
            end
            S_DW: begin
                if (i_sts.div_done) begin
                    n_state = S_ER;
                end
            end
            S_ER: begin
                w_cmd.elap_clr = 1'b1;
                w_cmd.rd_addr  = '0;
                n_k     = '0;
                n_state = S_EL;
            end
            S_EL: begin
                w_cmd.out_ld   = 1'b1;
                w_cmd.out_last = w_k_last;
                n_state = S_EW;
            end
            S_EW: begin
                if (i_sts.out_taken) begin
                    if (w_k_last) begin
                        n_cnt   = '0;
                        n_state = S_LOAD;
                    end else begin
                        w_cmd.rd_addr = IDX_W'(w_k_inc);
                        n_k     = w_k_inc;
                        n_state = S_EL;
                    end
                end
            end
            default: begin
                n_cnt   = '0;
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    assign o_in_ready = (r_state == S_LOAD);
    assign o_count    = r_cnt;
    assign o_cmd      = w_cmd;

endmodule

FILE: hw/rtl/shortest_job_first_timing_top.sv
// Non-preemptive shortest-job-first timing block.
// Input channel: one request per job (tag, burst, final flag), valid/ready.
// Output channel: one result per job in ascending burst order (ties keep
// arrival order) with wait and turnaround times; the last result of a set
// carries both averages with 8 fraction bits, truncated.
// Loading accepts one request per cycle; a set ends on the final flag or when
// MAX_JOBS requests are stored. While a set is processed, in_ready is low.
// Processing of n jobs runs these steps in order, paced by the job store's one
// read port and the bit-serial dividers:
//   sort: insertion of each job after the first, with one store write per
//         shifted entry (at most n(n-1)/2 shifts),
//   sums: one pass over the sorted store, averages: both dividers together,
//   emit: a setup step, then one result at a time while the receiver is
//         ready; a stalled result is held in the output register until taken.
// In_ready returns the cycle after the last result is taken.
// Reset (synchronous, active low) empties the set and drops any pending result.
// Depends on sjft_pkg, sjft_ctrl, sjft_dp.
`timescale 1ns / 1ps

module shortest_job_first_timing_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sjft_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sjft_pkg::t_out o_out_data
);
    import sjft_pkg::*;

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [CNT_W-1:0] w_count;

    sjft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_final    (i_in_data.final_job),
        .o_in_ready (o_in_ready),
        .o_count    (w_count),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    sjft_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_count     (w_count),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && o_in_ready))
        else $error("result pending while accepting requests");

    a_turn_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.turnaround ==
            TIME_W'(o_out_data.wait_time + TIME_W'(o_out_data.out_burst))))
        else $error("turnaround differs from wait plus burst");

    a_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last_result) |->
            (o_out_data.avg_wait == '0 && o_out_data.avg_turnaround == '0))
        else $error("averages nonzero before last result");

    a_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.last_result) |=> o_in_ready)
        else $error("not ready for a new set after last result");

    a_no_div_during_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_ld |-> w_sts.div_done)
        else $error("result loaded before averages finished");

endmodule

FILE: test/sjft_sched_checker.sv
// Scoreboard for the shortest-job-first timing block: watches both channels,
// predicts each set's schedule in burst order and compares every result.
// Depends on sjft_pkg.
`timescale 1ns / 1ps

module sjft_sched_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  logic           i_job_ready,
    input  sjft_pkg::t_in  i_job,
    input  logic           i_res_valid,
    input  logic           i_res_ready,
    input  sjft_pkg::t_out i_res,
    output int             o_mismatches,
    output int             o_pending
);
    import sjft_pkg::*;

    logic [TAG_W-1:0]   held_tag   [MAX_JOBS];
    logic [BURST_W-1:0] held_burst [MAX_JOBS];
    int                 held_count = 0;
    t_out               sched_q[$];
    t_out               exp_res;
    int                 mismatches = 0;

    assign o_mismatches = mismatches;

    // Stable insertion sort by burst, then wait/turnaround and averages.
    function automatic void schedule_set();
        logic [TAG_W-1:0]   t;
        logic [BURST_W-1:0] b;
        int                 j;
        longint unsigned    elapsed;
        longint unsigned    ta;
        longint unsigned    wsum;
        longint unsigned    tsum;
        t_out               r;
        for (int i = 1; i < held_count; i++) begin
            t = held_tag[i];
            b = held_burst[i];
            j = i;
            while (j > 0 && held_burst[j-1] > b) begin
                held_tag[j]   = held_tag[j-1];
                held_burst[j] = held_burst[j-1];
                j--;
            end
            held_tag[j]   = t;
            held_burst[j] = b;
        end
        elapsed = 0;
        wsum    = 0;
        tsum    = 0;
        for (int k = 0; k < held_count; k++) begin
            ta           = elapsed + held_burst[k];
            r            = '0;
            r.out_tag    = held_tag[k];
            r.out_burst  = held_burst[k];
            r.wait_time  = TIME_W'(elapsed);
            r.turnaround = TIME_W'(ta);
            wsum         += elapsed;
            tsum         += ta;
            elapsed      = ta;
            if (k == held_count - 1) begin
                r.avg_wait       = AVG_W'((wsum << FRAC_W) / longint'(held_count));
                r.avg_turnaround = AVG_W'((tsum << FRAC_W) / longint'(held_count));
                r.last_result    = 1'b1;
            end
            sched_q.push_back(r);
        end
        held_count = 0;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_job_valid && i_job_ready) begin
                held_tag[held_count]   = i_job.job_tag;
                held_burst[held_count] = i_job.job_burst;
                held_count++;
                if (i_job.final_job || held_count == MAX_JOBS) begin
                    schedule_set();
                end
            end
            if (i_res_valid && i_res_ready) begin
                if (sched_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result exp none got tag=%0d burst=%0d",
                                 $realtime, i_res.out_tag, i_res.out_burst);
                    end
                end else begin
                    exp_res = sched_q.pop_front();
                    if (i_res.out_tag        !== exp_res.out_tag        ||
                        i_res.out_burst      !== exp_res.out_burst      ||
                        i_res.wait_time      !== exp_res.wait_time      ||
                        i_res.turnaround     !== exp_res.turnaround     ||
                        i_res.avg_wait       !== exp_res.avg_wait       ||
                        i_res.avg_turnaround !== exp_res.avg_turnaround ||
                        i_res.last_result    !== exp_res.last_result) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  exp tag=%0d burst=%0d wait=%0d ta=%0d",
                                     exp_res.out_tag, exp_res.out_burst,
                                     exp_res.wait_time, exp_res.turnaround);
                            $display("      avg_w=%0d avg_ta=%0d last=%0d",
                                     exp_res.avg_wait, exp_res.avg_turnaround,
                                     exp_res.last_result);
                            $display("  got tag=%0d burst=%0d wait=%0d ta=%0d",
                                     i_res.out_tag, i_res.out_burst,
                                     i_res.wait_time, i_res.turnaround);
                            $display("      avg_w=%0d avg_ta=%0d last=%0d",
                                     i_res.avg_wait, i_res.avg_turnaround,
                                     i_res.last_result);
                        end
                    end
                end
            end
        end
        o_pending <= sched_q.size();
    end

endmodule

FILE: test/tb_top.sv
// Testbench top for shortest_job_first_timing_top: clock, reset, job stimulus
// with random gaps and result backpressure, watchdog and final verdict.
// Depends on sjft_pkg, sjft_sched_checker and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
    import sjft_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int JOB_TARGET  = 300;

    logic i_clk       = 1'b0;
    logic rst_n       = 1'b0;
    logic job_valid   = 1'b0;
    t_in  job_req     = '0;
    logic job_ready;
    logic sched_valid;
    logic sched_ready = 1'b0;
    t_out sched_res;

    int   mismatches;
    int   pending;
    int   quiet_cycles = 0;
    int   sent         = 0;
    logic gaps_on      = 1'b1;
    logic pressed      = 1'b0;
    int   set_size;
    int   pick;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    shortest_job_first_timing_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (job_valid),
        .o_in_ready  (job_ready),
        .i_in_data   (job_req),
        .o_out_valid (sched_valid),
        .i_out_ready (sched_ready),
        .o_out_data  (sched_res)
    );

    sjft_sched_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_job_valid  (job_valid),
        .i_job_ready  (job_ready),
        .i_job        (job_req),
        .i_res_valid  (sched_valid),
        .i_res_ready  (sched_ready),
        .i_res        (sched_res),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        sched_ready <= gaps_on ? ($urandom_range(99) >= 7) : 1'b1;
    end

    always @(posedge i_clk) begin
        if ((job_valid && job_ready) || (sched_valid && sched_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_job(input logic [TAG_W-1:0] tag, input logic [BURST_W-1:0] burst,
                            input logic fin);
        t_in req;
        req.job_tag   = tag;
        req.job_burst = burst;
        req.final_job = fin;
        while (gaps_on && $urandom_range(99) < 7) begin
            job_valid <= 1'b0;
            @(posedge i_clk);
        end
        job_valid <= 1'b1;
        job_req   <= req;
        @(posedge i_clk);
        while (!job_ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic wait_drained();
        job_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [BURST_W-1:0] pick_burst();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return BURST_W'($urandom_range(7));
            default: return BURST_W'($urandom_range(65535));
        endcase
    endfunction

    // A set of 16 closes on its own, so its final flag is left random.
    task automatic send_set(input int n);
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) begin
                send_job(TAG_W'($urandom_range(255)), pick_burst(),
                         (n == MAX_JOBS) ? 1'($urandom_range(1)) : 1'b1);
            end else begin
                send_job(TAG_W'($urandom_range(255)), pick_burst(), 1'b0);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        send_job(8'h00, 16'h0000, 1'b1);
        send_job(8'hFF, 16'hFFFF, 1'b1);
        // ties and zero bursts
        send_job(8'd1, 16'd300, 1'b0);
        send_job(8'd2, 16'd0,   1'b0);
        send_job(8'd3, 16'd300, 1'b0);
        send_job(8'd4, 16'd0,   1'b1);
        // full store, no final flag, widest sums
        for (int i = 0; i < MAX_JOBS; i++) begin
            send_job(8'hA0 + TAG_W'(i), 16'hFFFF, 1'b0);
        end
        wait_drained();

        while (sent < JOB_TARGET) begin
            gaps_on = !(sent >= 120 && sent < 200);
            if (!pressed && sent >= 240) begin
                wait_drained();
                pressed = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 75) begin
                set_size = $urandom_range(5, 1);
            end else if (pick < 93) begin
                set_size = $urandom_range(MAX_JOBS - 1, 6);
            end else begin
                set_size = MAX_JOBS;
            end
            send_set(set_size);
        end

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
